>>> sv/whp_pkg.sv
// Shared types and codes for the wave header parser.
// No dependencies; imported by whp_out_reg and wave_header_parser.
`default_nettype none

package whp_pkg;

  // Parse outcome codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RIFF  = 3'd1,
    ST_BAD_WAVE  = 3'd2,
    ST_FMT_SMALL = 3'd3,
    ST_BAD_CHAN  = 3'd4,
    ST_TRUNC     = 3'd5
  } status_t;

  // One header result
  typedef struct packed {
    status_t     status;
    logic [15:0] format_tag;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic        signed_samples;
    logic [31:0] data_length;
  } result_t;

  localparam int unsigned OutDataW = 104;

  // Packs a result into the stream word, first field in the lowest bits
  function automatic logic [OutDataW-1:0] pack_result(result_t r);
    logic [OutDataW-1:0] w;
    w = '0;
    w[2:0]    = r.status;
    w[18:3]   = r.format_tag;
    w[20:19]  = r.channel_count;
    w[52:21]  = r.sample_rate;
    w[68:53]  = r.bits_per_sample;
    w[69]     = r.signed_samples;
    w[101:70] = r.data_length;
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/whp_out_reg.sv
// Result register for the wave header parser: holds one result for the
// downstream side. Depends on whp_pkg.
`default_nettype none

module whp_out_reg
  import whp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire result_t             load_data,
  output logic                     room,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata
);

  logic    valid_r;
  result_t data_r;

  // Free when empty or when the held result leaves this cycle
  assign room = !valid_r || out_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (room && load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = pack_result(data_r);

endmodule

`default_nettype wire

>>> sv/wave_header_parser.sv
// Top level of the RIFF wave header parser: byte-wise parse state machine
// feeding the result register. Depends on whp_pkg and whp_out_reg.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  in_      | slave     | tdata: data_byte; tuser: start_of_file;
//           |           | tlast: end_of_stream
//  out_     | master    | tdata: status .. data_length, one header result
//
// One byte request is taken every cycle while in_tready is high; its combinational parse step sits
// between the accepted byte and the result register.
// A result appears on out_ in the cycle after the byte that completes it is accepted.
// in_tready drops only while a result is held and out_tready is low.
// Reset puts the parser in the idle phase, waiting for a start of file.
`default_nettype none

module wave_header_parser
  import whp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [7:0] data_byte
  input  wire logic                in_tuser,   // [0] start_of_file
  input  wire logic                in_tlast,   // end_of_stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata   // [2:0] status, [18:3] format_tag,
                                               // [20:19] channel_count,
                                               // [52:21] sample_rate,
                                               // [68:53] bits_per_sample,
                                               // [69] signed_samples,
                                               // [101:70] data_length
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_FLEN, PH_FTAG, PH_CHAN, PH_RATE,
    PH_AVG, PH_ALIGN, PH_BITS, PH_FEXTRA, PH_CID, PH_CLEN, PH_CSKIP, PH_DONE
  } phase_t;

  localparam logic [7:0] RiffId [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WaveId [8] = '{8'h57, 8'h41, 8'h56, 8'h45,
                                        8'h66, 8'h6d, 8'h74, 8'h20};
  localparam logic [7:0] DataId [4] = '{8'h64, 8'h61, 8'h74, 8'h61};
  localparam logic [31:0] FmtMin = 32'd16;

  phase_t      phase_r,  phase_nxt;
  logic [2:0]  idx_r,    idx_nxt;
  logic [31:0] fs_r,     fs_nxt;
  logic [31:0] skip_r,   skip_nxt;
  logic        cid_r,    cid_nxt;
  logic [15:0] tag_r,    tag_nxt;
  logic [1:0]  chan_r,   chan_nxt;
  logic [31:0] rate_r,   rate_nxt;
  logic [15:0] bits_r,   bits_nxt;

  logic        in_accept;
  logic        room;
  logic        res_valid;
  result_t     res;

  assign in_tready = room;
  assign in_accept = in_tvalid && in_tready;

  // Parse step for one byte
  always_comb begin
    phase_t      p;
    logic [2:0]  idx;
    logic [31:0] fs, skip, fs_g, skip_dec;
    logic        cid, match_riff, match_wave, match_data;
    logic [3:0]  idx_inc;
    logic [2:0]  idx_adv;
    logic        last2, last4, last8;
    logic [15:0] tag, bits;
    logic [1:0]  chan;
    logic [31:0] rate;

    // Start of file clears the parse first
    p    = in_tuser ? PH_RIFF : phase_r;
    idx  = in_tuser ? 3'd0    : idx_r;
    fs   = in_tuser ? 32'd0   : fs_r;
    skip = in_tuser ? 32'd0   : skip_r;
    cid  = in_tuser ? 1'b1    : cid_r;
    tag  = in_tuser ? 16'd0   : tag_r;
    chan = in_tuser ? 2'd0    : chan_r;
    rate = in_tuser ? 32'd0   : rate_r;
    bits = in_tuser ? 16'd0   : bits_r;

    fs_g     = fs | (32'(in_tdata) << {idx[1:0], 3'b000});
    idx_inc  = {1'b0, idx} + 4'd1;
    idx_adv  = idx_inc[2:0];
    last2    = idx_inc >= 4'd2;
    last4    = idx_inc >= 4'd4;
    last8    = idx_inc >= 4'd8;
    skip_dec = (skip != 32'd0) ? skip - 32'd1 : 32'd0;
    match_riff = in_tdata == RiffId[idx[1:0]];
    match_wave = in_tdata == WaveId[idx];
    match_data = in_tdata == DataId[idx[1:0]];

    phase_nxt = p;
    idx_nxt   = idx;
    fs_nxt    = fs;
    skip_nxt  = skip;
    cid_nxt   = cid;
    tag_nxt   = tag;
    chan_nxt  = chan;
    rate_nxt  = rate;
    bits_nxt  = bits;
    res_valid = 1'b0;
    res       = '0;
    res.status = ST_OK;

    if (p != PH_IDLE && p != PH_DONE && in_tlast) begin
      // Stream ended inside the header
      res_valid  = 1'b1;
      res.status = ST_TRUNC;
      phase_nxt  = PH_DONE;
    end else begin
      unique case (p)
        PH_IDLE, PH_DONE: begin
        end
        PH_RIFF: begin
          cid_nxt = cid && match_riff;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt = 32'd0;
            if (!(cid && match_riff)) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_RIFF;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          fs_nxt  = fs_g;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt    = 32'd0;
            cid_nxt   = 1'b1;
            phase_nxt = PH_WAVE;
          end
        end
        PH_WAVE: begin
          cid_nxt = cid && match_wave;
          idx_nxt = last8 ? 3'd0 : idx_adv;
          if (last8) begin
            fs_nxt = 32'd0;
            if (!(cid && match_wave)) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_WAVE;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_FLEN;
            end
          end
        end
        PH_FLEN: begin
          fs_nxt  = fs_g;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt = 32'd0;
            if (fs_g < FmtMin) begin
              res_valid  = 1'b1;
              res.status = ST_FMT_SMALL;
              phase_nxt  = PH_DONE;
            end else begin
              skip_nxt  = fs_g - FmtMin;
              phase_nxt = PH_FTAG;
            end
          end
        end
        PH_FTAG: begin
          fs_nxt  = fs_g;
          idx_nxt = last2 ? 3'd0 : idx_adv;
          if (last2) begin
            tag_nxt   = fs_g[15:0];
            fs_nxt    = 32'd0;
            phase_nxt = PH_CHAN;
          end
        end
        PH_CHAN: begin
          fs_nxt  = fs_g;
          idx_nxt = last2 ? 3'd0 : idx_adv;
          if (last2) begin
            fs_nxt = 32'd0;
            if (fs_g != 32'd1 && fs_g != 32'd2) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_CHAN;
              phase_nxt  = PH_DONE;
            end else begin
              chan_nxt  = fs_g[1:0];
              phase_nxt = PH_RATE;
            end
          end
        end
        PH_RATE: begin
          fs_nxt  = fs_g;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            rate_nxt  = fs_g;
            fs_nxt    = 32'd0;
            phase_nxt = PH_AVG;
          end
        end
        PH_AVG: begin
          fs_nxt  = fs_g;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt    = 32'd0;
            phase_nxt = PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          fs_nxt  = fs_g;
          idx_nxt = last2 ? 3'd0 : idx_adv;
          if (last2) begin
            fs_nxt    = 32'd0;
            phase_nxt = PH_BITS;
          end
        end
        PH_BITS: begin
          fs_nxt  = fs_g;
          idx_nxt = last2 ? 3'd0 : idx_adv;
          if (last2) begin
            bits_nxt = fs_g[15:0];
            fs_nxt   = 32'd0;
            if (skip != 32'd0) begin
              phase_nxt = PH_FEXTRA;
            end else begin
              phase_nxt = PH_CID;
              idx_nxt   = 3'd0;
              cid_nxt   = 1'b1;
            end
          end
        end
        PH_FEXTRA, PH_CSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = PH_CID;
            idx_nxt   = 3'd0;
            cid_nxt   = 1'b1;
          end
        end
        PH_CID: begin
          cid_nxt = cid && match_data;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt    = 32'd0;
            phase_nxt = PH_CLEN;
          end
        end
        PH_CLEN: begin
          fs_nxt  = fs_g;
          idx_nxt = last4 ? 3'd0 : idx_adv;
          if (last4) begin
            fs_nxt = 32'd0;
            if (cid) begin
              // Data chunk found: header result
              res_valid           = 1'b1;
              res.status          = ST_OK;
              res.format_tag      = tag;
              res.channel_count   = chan;
              res.sample_rate     = rate;
              res.bits_per_sample = bits;
              res.signed_samples  = bits != 16'd8;
              res.data_length     = fs_g;
              phase_nxt           = PH_DONE;
            end else begin
              skip_nxt = fs_g;
              if (fs_g != 32'd0) begin
                phase_nxt = PH_CSKIP;
              end else begin
                phase_nxt = PH_CID;
                idx_nxt   = 3'd0;
                cid_nxt   = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  // Parse state, updated per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= 3'd0;
      fs_r    <= 32'd0;
      skip_r  <= 32'd0;
      cid_r   <= 1'b0;
      tag_r   <= 16'd0;
      chan_r  <= 2'd0;
      rate_r  <= 32'd0;
      bits_r  <= 16'd0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      fs_r    <= fs_nxt;
      skip_r  <= skip_nxt;
      cid_r   <= cid_nxt;
      tag_r   <= tag_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
    end
  end

  // Result register
  whp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept && res_valid),
    .load_data  (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Checks
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res_valid) |=> (phase_r == PH_DONE))
    else $error("parser not done after a result");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != ST_OK) |->
      (out_tdata[101:3] == 99'd0))
    else $error("error result carries header fields");

  a_ok_channels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] == ST_OK) |->
      (out_tdata[20:19] == 2'd1 || out_tdata[20:19] == 2'd2))
    else $error("ok result with bad channel count");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

endmodule

`default_nettype wire
